/* hw/rtl/orss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orss_pkg
// Types and constants shared by the object record symbol scanner.
// ----------------------------------------------------------------------------
package orss_pkg;

  localparam int unsigned SLOT_BITS  = 8;
  localparam int unsigned SLOT_COUNT = 1 << SLOT_BITS;
  localparam int unsigned LIMIT_BITS = 16;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd4096;

  // record opcodes
  localparam logic [15:0] OPC_NAME    = 16'd126;
  localparam logic [15:0] OPC_SIGNAME = 16'd332;
  localparam logic [15:0] OPC_DATA    = 16'd45;
  localparam logic [15:0] OPC_BSS     = 16'd53;
  localparam logic [15:0] OPC_TEXT    = 16'd220;

  // name record types
  localparam logic [7:0] KIND_EXTERN = 8'd61;
  localparam logic [7:0] KIND_STATIC = 8'd62;
  localparam logic [7:0] KIND_HIST0  = 8'd69;
  localparam logic [7:0] KIND_HIST1  = 8'd70;

  localparam logic [4:0] CONST_WIDE = 5'd8;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SYMBOL  = 2'd1;
  localparam logic [1:0] EV_SECTION = 2'd2;

  // section codes
  localparam logic [1:0] SECT_TEXT = 2'd0;
  localparam logic [1:0] SECT_DATA = 2'd1;
  localparam logic [1:0] SECT_BSS  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  slot;
    logic        symbol_kind;
    logic [1:0]  section;
    logic [31:0] name_offset;
    logic [15:0] name_length;
    logic        final_res;
    logic        ended_mid_record;
  } out_t;

  // slot table access from the parser
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    logic                 wr_data;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 clear;
  } slot_req_t;

endpackage

/* hw/rtl/orss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module orss_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/orss_slot_tbl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orss_slot_tbl
// Slot valid table: valid bits in RAM, qualified by per-slot written flags
// that clear all at once at reset and at end of file.
// ----------------------------------------------------------------------------
module orss_slot_tbl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  orss_pkg::slot_req_t req_i,
  output logic                valid_o
);
  import orss_pkg::*;

  logic [SLOT_COUNT-1:0] written_q;
  logic [SLOT_BITS-1:0]  raddr_q;
  logic                  rdata;

  orss_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .raddr_i (req_i.rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      raddr_q   <= '0;
    end else begin
      raddr_q <= req_i.rd_addr;
      if (req_i.clear) begin
        written_q <= '0;
      end else if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  // entries never written since the last clear read as invalid
  assign valid_o = written_q[raddr_q] & rdata;

endmodule

/* hw/rtl/orss_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orss_parser
// Record parser: walks opcodes, name records and address records one byte
// per request and produces symbol and section events.
// ----------------------------------------------------------------------------
module orss_parser #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  orss_pkg::in_t                 in_i,
  input  logic [orss_pkg::LIMIT_BITS-1:0] limit_i,
  input  logic                          slot_valid_i,
  output orss_pkg::slot_req_t           slot_req_o,
  output logic                          emit_o,
  output orss_pkg::out_t                out_o
);
  import orss_pkg::*;

  localparam logic [3:0] PH_OPLO   = 4'd0;
  localparam logic [3:0] PH_OPHI   = 4'd1;
  localparam logic [3:0] PH_SIG    = 4'd2;
  localparam logic [3:0] PH_NTYPE  = 4'd3;
  localparam logic [3:0] PH_NSLOT  = 4'd4;
  localparam logic [3:0] PH_NAME   = 4'd5;
  localparam logic [3:0] PH_LINE   = 4'd6;
  localparam logic [3:0] PH_AFLAGS = 4'd7;
  localparam logic [3:0] PH_ABODY  = 4'd8;

  // bytes after the slot byte in an address body
  function automatic logic [4:0] tail_after_slot(input logic [7:0] f);
    logic [4:0] n;
    n = '0;
    if (f[3] || f[5]) n = CONST_WIDE;
    if (f[0]) n = n + 5'd1;
    return n;
  endfunction

  function automatic logic [4:0] body_size(input logic [7:0] f);
    logic [4:0] n;
    n = tail_after_slot(f);
    if (f[1]) n = n + 5'd2;
    if (f[2]) n = n + 5'd4;
    if (f[4]) n = n + 5'd1;
    return n;
  endfunction

  logic [3:0]             phase_q, phase_d;
  logic [15:0]            opcode_q, opcode_d;
  logic [4:0]             bytes_left_q, bytes_left_d;
  logic [7:0]             addr_flags_q, addr_flags_d;
  logic                   in_second_q, in_second_d;
  logic [7:0]             ref_slot_q, ref_slot_d;
  logic                   ref_present_q, ref_present_d;
  logic [7:0]             record_type_q, record_type_d;
  logic [7:0]             record_slot_q, record_slot_d;
  logic [15:0]            name_count_q, name_count_d;
  logic [OFFSET_BITS-1:0] name_base_q, name_base_d;
  logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;

  logic        addr_done;
  logic [4:0]  bl_dec;
  logic [4:0]  body;
  logic [15:0] opc;
  logic        is_sec;
  logic [1:0]  sec;
  logic        name_ok;
  logic [63:0] start_ext;

  assign bl_dec    = bytes_left_q - 5'd1;
  assign body      = body_size(in_i.data_byte);
  assign opc       = {in_i.data_byte, opcode_q[7:0]};
  assign start_ext = 64'(name_base_q);
  assign name_ok   = (record_type_q == KIND_EXTERN || record_type_q == KIND_STATIC)
                     && name_count_q != 16'd0 && name_count_q < limit_i;

  always_comb begin
    is_sec = 1'b1;
    sec    = SECT_TEXT;
    if (opcode_q == OPC_TEXT) begin
      sec = SECT_TEXT;
    end else if (opcode_q == OPC_DATA) begin
      sec = SECT_DATA;
    end else if (opcode_q == OPC_BSS) begin
      sec = SECT_BSS;
    end else begin
      is_sec = 1'b0;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    opcode_d      = opcode_q;
    bytes_left_d  = bytes_left_q;
    addr_flags_d  = addr_flags_q;
    in_second_d   = in_second_q;
    ref_slot_d    = ref_slot_q;
    ref_present_d = ref_present_q;
    record_type_d = record_type_q;
    record_slot_d = record_slot_q;
    name_count_d  = name_count_q;
    name_base_d   = name_base_q;
    byte_offset_d = byte_offset_q;
    addr_done     = 1'b0;
    out_o         = '0;
    emit_o        = 1'b0;
    slot_req_o         = '0;
    slot_req_o.wr_addr = record_slot_q;

    if (step_i) begin
      unique case (phase_q)
        PH_OPLO: begin
          opcode_d = {8'd0, in_i.data_byte};
          phase_d  = PH_OPHI;
        end
        PH_OPHI: begin
          opcode_d = opc;
          if (opc == OPC_NAME) begin
            phase_d = PH_NTYPE;
          end else if (opc == OPC_SIGNAME) begin
            phase_d      = PH_SIG;
            bytes_left_d = 5'd4;
          end else begin
            phase_d       = PH_LINE;
            bytes_left_d  = 5'd4;
            ref_present_d = 1'b0;
            in_second_d   = 1'b0;
          end
        end
        PH_SIG: begin
          bytes_left_d = bl_dec;
          if (bl_dec == 5'd0) phase_d = PH_NTYPE;
        end
        PH_NTYPE: begin
          record_type_d = in_i.data_byte;
          phase_d       = PH_NSLOT;
        end
        PH_NSLOT: begin
          record_slot_d = in_i.data_byte;
          name_count_d  = '0;
          name_base_d   = byte_offset_q + OFFSET_BITS'(1);
          phase_d       = PH_NAME;
        end
        PH_NAME: begin
          if (in_i.data_byte != 8'd0) begin
            if (name_count_q != 16'hFFFF) name_count_d = name_count_q + 16'd1;
          end else begin
            if (name_ok) begin
              slot_req_o.wr_en    = 1'b1;
              slot_req_o.wr_data  = 1'b1;
              out_o.event_res     = EV_SYMBOL;
              out_o.slot          = record_slot_q;
              out_o.symbol_kind   = (record_type_q == KIND_STATIC);
              out_o.name_offset   = start_ext[31:0];
              out_o.name_length   = name_count_q;
            end else if (record_type_q == KIND_HIST0 || record_type_q == KIND_HIST1) begin
              slot_req_o.wr_en   = 1'b1;
              slot_req_o.wr_data = 1'b0;
            end
            phase_d = PH_OPLO;
          end
        end
        PH_LINE: begin
          bytes_left_d = bl_dec;
          if (bl_dec == 5'd0) phase_d = PH_AFLAGS;
        end
        PH_AFLAGS: begin
          addr_flags_d = in_i.data_byte;
          bytes_left_d = body;
          if (body == 5'd0) begin
            addr_done = 1'b1;
          end else begin
            phase_d = PH_ABODY;
          end
        end
        PH_ABODY: begin
          if (!in_second_q && addr_flags_q[4]
              && bytes_left_q == tail_after_slot(addr_flags_q) + 5'd1) begin
            ref_slot_d    = in_i.data_byte;
            ref_present_d = 1'b1;
          end
          bytes_left_d = bl_dec;
          if (bl_dec == 5'd0) addr_done = 1'b1;
        end
        default: begin
          phase_d = PH_OPLO;
        end
      endcase

      if (addr_done) begin
        if (!in_second_q) begin
          in_second_d = 1'b1;
          phase_d     = PH_AFLAGS;
        end else begin
          // valid bit of ref_slot_q has been read since the slot byte
          if (is_sec && ref_present_q && slot_valid_i) begin
            out_o.event_res = EV_SECTION;
            out_o.slot      = ref_slot_q;
            out_o.section   = sec;
          end
          in_second_d = 1'b0;
          phase_d     = PH_OPLO;
        end
      end

      byte_offset_d = byte_offset_q + OFFSET_BITS'(1);

      out_o.final_res        = in_i.last;
      out_o.ended_mid_record = in_i.last && (phase_d != PH_OPLO);
      emit_o = (out_o.event_res != EV_NONE) || in_i.last;

      // end of file: restart for the next file
      if (in_i.last) begin
        phase_d       = PH_OPLO;
        opcode_d      = '0;
        bytes_left_d  = '0;
        addr_flags_d  = '0;
        in_second_d   = 1'b0;
        ref_slot_d    = '0;
        ref_present_d = 1'b0;
        record_type_d = '0;
        record_slot_d = '0;
        name_count_d  = '0;
        name_base_d   = '0;
        byte_offset_d = '0;
        slot_req_o.clear = 1'b1;
      end
    end

    // read ahead so the valid bit is ready the cycle after the slot byte
    slot_req_o.rd_addr = ref_slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_OPLO;
      opcode_q      <= '0;
      bytes_left_q  <= '0;
      addr_flags_q  <= '0;
      in_second_q   <= 1'b0;
      ref_slot_q    <= '0;
      ref_present_q <= 1'b0;
      record_type_q <= '0;
      record_slot_q <= '0;
      name_count_q  <= '0;
      name_base_q   <= '0;
      byte_offset_q <= '0;
    end else begin
      phase_q       <= phase_d;
      opcode_q      <= opcode_d;
      bytes_left_q  <= bytes_left_d;
      addr_flags_q  <= addr_flags_d;
      in_second_q   <= in_second_d;
      ref_slot_q    <= ref_slot_d;
      ref_present_q <= ref_present_d;
      record_type_q <= record_type_d;
      record_slot_q <= record_slot_d;
      name_count_q  <= name_count_d;
      name_base_q   <= name_base_d;
      byte_offset_q <= byte_offset_d;
    end
  end

endmodule

/* hw/rtl/object_record_symbol_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_record_symbol_scanner
// Scans an object file byte stream and reports symbol and section events.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one file byte per
//   request, with last marking the final byte of a file.
//   out channel (out_valid_o/out_ready_i/out_data_o) gives at most one
//   result per byte: a symbol or section event, or a final result on the
//   last byte that flags a truncated record.
//   cfg channel writes the name length limit (reset 4096); always ready.
// Throughput is one byte per cycle unless the receiver stalls; a result is
// registered, appearing in the cycle after its byte is accepted. Slot valid
// bits live in a 256 x 1 RAM read ahead of use; per-slot written flags make
// reset and end-of-file clears take effect at once, with no clearing pass.
// When the receiver stalls, one result waits in the output register and a
// new byte is still taken if the output register is empty or being drained.
// Reset clears the parser, offset counter and all slot valid bits.
// ----------------------------------------------------------------------------
module object_record_symbol_scanner #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  orss_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output orss_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [orss_pkg::LIMIT_BITS-1:0] cfg_data_i
);
  import orss_pkg::*;

  logic [LIMIT_BITS-1:0] limit_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_data_q, out_data_d;
  logic                  step;
  logic                  emit;
  out_t                  res;
  slot_req_t             slot_req;
  logic                  slot_valid;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  orss_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .in_i         (in_data_i),
    .limit_i      (limit_q),
    .slot_valid_i (slot_valid),
    .slot_req_o   (slot_req),
    .emit_o       (emit),
    .out_o        (res)
  );

  orss_slot_tbl u_slot_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (slot_req),
    .valid_o (slot_valid)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
